[src/bsgi_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bad sample gap interpolator.
package bsgi_pkg;

   localparam int IDX_W    = 10;  // buffer index width
   localparam int CODE_W   = 24;  // sample code width
   localparam int NUM_CHAN = 4;
   localparam int POS_W    = 11;  // holds gap start plus the largest offset before wrap
   localparam int CNT_W    = 5;   // counts the CODE_W divide steps

   typedef struct packed {
      logic [IDX_W-1:0]         sample_index;
      logic                     good;
      logic signed [CODE_W-1:0] chan0_in;
      logic signed [CODE_W-1:0] chan1_in;
      logic signed [CODE_W-1:0] chan2_in;
      logic signed [CODE_W-1:0] chan3_in;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         write_index;
      logic signed [CODE_W-1:0] chan0_out;
      logic signed [CODE_W-1:0] chan1_out;
      logic signed [CODE_W-1:0] chan2_out;
      logic signed [CODE_W-1:0] chan3_out;
      logic                     last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;      // input transfer this cycle
      logic div_step;    // one restoring divide step on all lanes
      logic pos_reduce;  // fold the write position below the buffer depth
      logic emit_load;   // load the first point of the fill
      logic emit_next;   // result transfer, step to the next point
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fill_start;  // the offered sample closes an open gap
      logic pos_ok;      // write position is below the buffer depth
      logic last;        // current point is the final one of the gap
   } status_type;

endpackage

[src/bsgi_controller.sv]
`timescale 1ns / 1ps
// Sequencer for the gap interpolator: accept, divide, then emit one point per transfer.
module bsgi_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bsgi_pkg::status_type status,
   output bsgi_pkg::cmd_type    cmd
);

   bsgi_pkg::state_type state_ff, state_in;
   logic [bsgi_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic div_busy;

   assign div_busy = (cnt_ff != bsgi_pkg::CNT_W'(bsgi_pkg::CODE_W));

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsgi_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         bsgi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.fill_start) begin
                  state_in = bsgi_pkg::ST_DIVIDE;
                  cnt_in   = '0;
               end
            end
         end
         bsgi_pkg::ST_DIVIDE: begin
            cmd.pos_reduce = 1'b1;
            if (div_busy) begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
            end else if (status.pos_ok) begin
               cmd.emit_load = 1'b1;
               state_in      = bsgi_pkg::ST_EMIT;
            end
         end
         bsgi_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_next = 1'b1;
               if (status.last) begin
                  state_in = bsgi_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = bsgi_pkg::ST_IDLE;
         end
      endcase
   end

   // one item in flight: never take a sample while results are pending
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("input accepted during gap fill");

   // results only appear once the divide has run its full length
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cnt_ff) == bsgi_pkg::CNT_W'(bsgi_pkg::CODE_W))
      else $error("fill started before divide finished");

endmodule

[src/bsgi_datapath.sv]
`timescale 1ns / 1ps
// Gap tracking state, per-channel divider lanes and the incremental fill arithmetic.
module bsgi_datapath #(
   parameter int BUFFER_DEPTH = 1024,
   parameter int MAX_GAP      = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bsgi_pkg::req_type    req,
   input  bsgi_pkg::cmd_type    cmd,
   output bsgi_pkg::status_type status,
   output bsgi_pkg::rsp_type    rsp
);

   localparam int LEN_W = $clog2(MAX_GAP + 1);
   localparam int DIV_W = $clog2(MAX_GAP + 2);
   localparam int CW    = bsgi_pkg::CODE_W;
   localparam int NC    = bsgi_pkg::NUM_CHAN;

   // gap tracking
   logic                        gap_open_ff, gap_open_in;
   logic                        have_prev_ff, have_prev_in;
   logic [bsgi_pkg::IDX_W-1:0]  gap_start_ff, gap_start_in;
   logic [LEN_W-1:0]            gap_len_ff, gap_len_in;
   logic signed [CW-1:0]        prev_ff [NC];
   logic signed [CW-1:0]        prev_in [NC];

   // fill working registers
   logic signed [CW-1:0]        cur_ff [NC];
   logic signed [CW-1:0]        cur_in [NC];
   logic [NC-1:0]               neg_ff, neg_in;
   logic [CW-1:0]               dvd_ff [NC];   // |delta|, then quotient
   logic [CW-1:0]               dvd_in [NC];
   logic [DIV_W-1:0]            rem_ff [NC];
   logic [DIV_W-1:0]            rem_in [NC];
   logic [CW-1:0]               acc_q_ff [NC];
   logic [CW-1:0]               acc_q_in [NC];
   logic [DIV_W-1:0]            acc_r_ff [NC];
   logic [DIV_W-1:0]            acc_r_in [NC];
   logic [DIV_W-1:0]            divisor_ff, divisor_in;
   logic [LEN_W-1:0]            k_ff, k_in;
   logic [bsgi_pkg::POS_W-1:0]  pos_ff, pos_in;

   // combinational helpers
   logic                        idx_zero, open_eff, have_eff;
   logic signed [CW-1:0]        chan_in [NC];
   logic signed [CW:0]          delta [NC];
   logic [CW:0]                 mag [NC];
   logic [DIV_W:0]              part [NC];
   logic [DIV_W:0]              rsum [NC];
   logic signed [CW+1:0]        fill_val [NC];

   assign chan_in[0] = req.chan0_in;
   assign chan_in[1] = req.chan1_in;
   assign chan_in[2] = req.chan2_in;
   assign chan_in[3] = req.chan3_in;

   // index zero restarts the gap state before the sample is handled
   assign idx_zero = (req.sample_index == '0);
   assign open_eff = gap_open_ff & ~idx_zero;
   assign have_eff = have_prev_ff & ~idx_zero;

   assign status.fill_start = req.good & open_eff;
   assign status.pos_ok     = (32'(pos_ff) < BUFFER_DEPTH);
   assign status.last       = (k_ff == gap_len_ff);

   // lane arithmetic
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         delta[c] = {chan_in[c][CW-1], chan_in[c]} - {prev_ff[c][CW-1], prev_ff[c]};
         mag[c]   = delta[c][CW] ? (CW+1)'(-delta[c]) : (CW+1)'(delta[c]);
         part[c]  = {rem_ff[c], dvd_ff[c][CW-1]};
         rsum[c]  = {1'b0, acc_r_ff[c]} + {1'b0, rem_ff[c]};
         if (neg_ff[c]) begin
            fill_val[c] = {{2{prev_ff[c][CW-1]}}, prev_ff[c]} - {2'b00, acc_q_ff[c]};
         end else begin
            fill_val[c] = {{2{prev_ff[c][CW-1]}}, prev_ff[c]} + {2'b00, acc_q_ff[c]};
         end
      end
   end

   // next-state logic
   always_comb begin
      gap_open_in  = gap_open_ff;
      have_prev_in = have_prev_ff;
      gap_start_in = gap_start_ff;
      gap_len_in   = gap_len_ff;
      neg_in       = neg_ff;
      divisor_in   = divisor_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      for (int c = 0; c < NC; c++) begin
         prev_in[c]  = prev_ff[c];
         cur_in[c]   = cur_ff[c];
         dvd_in[c]   = dvd_ff[c];
         rem_in[c]   = rem_ff[c];
         acc_q_in[c] = acc_q_ff[c];
         acc_r_in[c] = acc_r_ff[c];
      end

      // sample transfer
      if (cmd.accept) begin
         if (req.good) begin
            if (open_eff) begin
               // closing a gap: set up the divide of |cur - prev| by N + 1
               for (int c = 0; c < NC; c++) begin
                  cur_in[c] = chan_in[c];
                  neg_in[c] = delta[c][CW];
                  dvd_in[c] = mag[c][CW-1:0];
                  rem_in[c] = '0;
               end
               divisor_in = DIV_W'(gap_len_ff) + DIV_W'(1);
               pos_in     = bsgi_pkg::POS_W'(gap_start_ff);
            end else begin
               for (int c = 0; c < NC; c++) begin
                  prev_in[c] = chan_in[c];
               end
               have_prev_in = 1'b1;
               gap_open_in  = 1'b0;
               gap_len_in   = '0;
            end
         end else begin
            if (!have_eff) begin
               for (int c = 0; c < NC; c++) begin
                  prev_in[c] = chan_in[c];
               end
            end
            have_prev_in = 1'b1;
            if (!open_eff) begin
               gap_open_in  = 1'b1;
               gap_start_in = req.sample_index;
               gap_len_in   = LEN_W'(1);
            end else if (gap_len_ff < LEN_W'(MAX_GAP)) begin
               gap_len_in = gap_len_ff + 1'b1;
            end
         end
      end

      // restoring divide, one quotient bit per lane per cycle
      if (cmd.div_step) begin
         for (int c = 0; c < NC; c++) begin
            if (part[c] >= {1'b0, divisor_ff}) begin
               rem_in[c] = DIV_W'(part[c] - {1'b0, divisor_ff});
               dvd_in[c] = {dvd_ff[c][CW-2:0], 1'b1};
            end else begin
               rem_in[c] = part[c][DIV_W-1:0];
               dvd_in[c] = {dvd_ff[c][CW-2:0], 1'b0};
            end
         end
      end

      // wrap the gap start into the buffer
      if (cmd.pos_reduce && !status.pos_ok) begin
         pos_in = pos_ff - bsgi_pkg::POS_W'(BUFFER_DEPTH);
      end

      // first point: k = 1 gives the plain quotient and remainder
      if (cmd.emit_load) begin
         for (int c = 0; c < NC; c++) begin
            acc_q_in[c] = dvd_ff[c];
            acc_r_in[c] = rem_ff[c];
         end
         k_in = LEN_W'(1);
      end

      // result transfer: add one more quotient/remainder step per point
      if (cmd.emit_next) begin
         for (int c = 0; c < NC; c++) begin
            if (rsum[c] >= {1'b0, divisor_ff}) begin
               acc_r_in[c] = DIV_W'(rsum[c] - {1'b0, divisor_ff});
               acc_q_in[c] = acc_q_ff[c] + dvd_ff[c] + CW'(1);
            end else begin
               acc_r_in[c] = rsum[c][DIV_W-1:0];
               acc_q_in[c] = acc_q_ff[c] + dvd_ff[c];
            end
         end
         k_in = k_ff + 1'b1;
         if (32'(pos_ff) + 32'd1 == BUFFER_DEPTH) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
         if (status.last) begin
            for (int c = 0; c < NC; c++) begin
               prev_in[c] = cur_ff[c];
            end
            have_prev_in = 1'b1;
            gap_open_in  = 1'b0;
            gap_len_in   = '0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_open_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
         gap_start_ff <= '0;
         gap_len_ff   <= '0;
         for (int c = 0; c < NC; c++) begin
            prev_ff[c] <= '0;
         end
      end else begin
         gap_open_ff  <= gap_open_in;
         have_prev_ff <= have_prev_in;
         gap_start_ff <= gap_start_in;
         gap_len_ff   <= gap_len_in;
         for (int c = 0; c < NC; c++) begin
            prev_ff[c] <= prev_in[c];
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      divisor_ff <= divisor_in;
      k_ff       <= k_in;
      pos_ff     <= pos_in;
      for (int c = 0; c < NC; c++) begin
         cur_ff[c]   <= cur_in[c];
         dvd_ff[c]   <= dvd_in[c];
         rem_ff[c]   <= rem_in[c];
         acc_q_ff[c] <= acc_q_in[c];
         acc_r_ff[c] <= acc_r_in[c];
      end
   end

   // result fields
   assign rsp.write_index = pos_ff[bsgi_pkg::IDX_W-1:0];
   assign rsp.chan0_out   = fill_val[0][CW-1:0];
   assign rsp.chan1_out   = fill_val[1][CW-1:0];
   assign rsp.chan2_out   = fill_val[2][CW-1:0];
   assign rsp.chan3_out   = fill_val[3][CW-1:0];
   assign rsp.last        = status.last;

   // an open gap always has a stored previous sample and a nonzero length
   assert property (@(posedge clock) disable iff (reset) gap_open_ff |-> have_prev_ff)
      else $error("gap open without previous sample");

   assert property (@(posedge clock) disable iff (reset)
      gap_open_ff |-> (gap_len_ff != '0 && gap_len_ff <= LEN_W'(MAX_GAP)))
      else $error("gap length out of range");

   // running remainder stays below the divisor, so one subtract is enough
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_next |-> (acc_r_ff[0] < divisor_ff && rem_ff[0] < divisor_ff))
      else $error("fill remainder overflow");

endmodule

[src/bad_sample_gap_interpolator.sv]
`timescale 1ns / 1ps
// A sample that closes no gap is taken on its transfer and gives no result.
// A sample closing a gap of N points: the transfer, then the shared-step restoring divider
// (one quotient bit per cycle, four lanes) while the gap start is folded below BUFFER_DEPTH,
// a load of the first point, then N results at one per cycle while rsp_ready is high.
// One item is in flight at a time; input is accepted only between fills.
// Synchronous active-high reset clears the gap state and the previous sample.
module bad_sample_gap_interpolator #(
   parameter int BUFFER_DEPTH = 1024,
   parameter int MAX_GAP      = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bsgi_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bsgi_pkg::rsp_type rsp_payload
);

   bsgi_pkg::cmd_type    cmd;
   bsgi_pkg::status_type status;

   bsgi_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsgi_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .MAX_GAP      (MAX_GAP)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req    (req_payload),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_payload)
   );

endmodule
